### sv/tile_nonzero_pixel_counter_core_assert.svh
// Assertion macros used by the checker file of the tile counter
`ifndef TILE_NONZERO_PIXEL_COUNTER_CORE_ASSERT_SVH
`define TILE_NONZERO_PIXEL_COUNTER_CORE_ASSERT_SVH

// same-cycle implication
`define TNPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tnpc assertion failed");

// next-cycle implication
`define TNPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tnpc assertion failed");

`endif

### sv/tnpc_pkg.sv
// Shared constants and types of the tile nonzero pixel counter
package tnpc_pkg;

    localparam int TILE_SIZE   = 8;
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    localparam int CFG_W   = 7;
    localparam int PIXEL_W = 8;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 12;
    localparam int TOTAL_W = 19;

    localparam int CFG_RESET_COLUMNS = 64;
    localparam int CFG_RESET_ROWS    = 64;

    localparam int X_W   = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SEG_W = $clog2(TILE_SIZE + 1);
    localparam int SUM_W = $clog2(TILE_SIZE * TILE_SIZE + 1);

    localparam int CMP_BASE = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W    = ((CMP_BASE > CFG_W) ? CMP_BASE : CFG_W) + 1;
    localparam int PROD_W   = ROW_W + COL_W + 2;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic [COL_W:0] t_cols;
    typedef logic [ROW_W:0] t_rows;

    typedef enum logic [0:0] {
        CFG_GRID_COLUMNS   = 1'b0,
        CFG_GRID_ROWS_USED = 1'b1
    } t_cfg_index;

    // one finished pixel run of a tile line, handed from front to back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [SEG_W-1:0] seg;
        logic             first_line;
        logic             last_line;
        logic             frame_last;
        logic [ROW_W-1:0] flipped;
        t_cols            cols;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] tile_count;
        logic [INDEX_W-1:0] tile_index;
        logic [TOTAL_W-1:0] running_total;
        logic               frame_done;
    } t_result;

endpackage

### sv/tnpc_ram.sv
// Generic single-write, single-read RAM with registered read data
module tnpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tnpc_front.sv
// Front end: raster position counters, per-run pixel count and command queue
module tnpc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [tnpc_pkg::PIXEL_W-1:0]  i_pixel,
    output logic                          o_full,
    input  tnpc_pkg::t_cols               i_cols,
    input  tnpc_pkg::t_rows               i_rows,
    output logic                          o_cmd_valid,
    output tnpc_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);

    localparam int XW  = tnpc_pkg::X_W;
    localparam int CW  = tnpc_pkg::COL_W;
    localparam int RW  = tnpc_pkg::ROW_W;
    localparam int SW  = tnpc_pkg::SEG_W;
    localparam int MW  = tnpc_pkg::CMP_W;
    localparam int PW  = tnpc_pkg::CMD_PTR_W;
    localparam int NW  = tnpc_pkg::CMD_CNT_W;

    logic [XW-1:0] r_x, n_x;
    logic [XW-1:0] r_line, n_line;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [SW-1:0] r_seg;
    logic [SW-1:0] seg_next;

    logic accept, push, last_x, last_line, last_col, last_row;
    logic [RW-1:0] flipped;
    tnpc_pkg::t_cmd cmd_in;

    tnpc_pkg::t_cmd r_q [tnpc_pkg::CMD_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [NW-1:0]  r_cnt;

    assign o_full      = (r_cnt == NW'(tnpc_pkg::CMD_DEPTH));
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        last_x    = (r_x == XW'(tnpc_pkg::TILE_SIZE - 1));
        last_line = (r_line == XW'(tnpc_pkg::TILE_SIZE - 1));
        last_col  = (MW'(r_col) + MW'(1) >= MW'(i_cols));
        last_row  = (MW'(r_row) + MW'(1) >= MW'(i_rows));
        seg_next  = ((r_x == '0) ? '0 : r_seg) + SW'(|i_pixel);
        // rows counted from the bottom; a row past the count maps to zero
        if (MW'(r_row) < MW'(i_rows)) begin
            flipped = RW'(MW'(i_rows) - MW'(r_row) - MW'(1));
        end else begin
            flipped = '0;
        end
        push = accept && last_x;

        cmd_in.col        = r_col;
        cmd_in.seg        = seg_next;
        cmd_in.first_line = (r_line == '0);
        cmd_in.last_line  = last_line;
        cmd_in.frame_last = last_col && last_row;
        cmd_in.flipped    = flipped;
        cmd_in.cols       = i_cols;

        n_x    = r_x;
        n_col  = r_col;
        n_line = r_line;
        n_row  = r_row;
        if (accept) begin
            if (!last_x) begin
                n_x = r_x + XW'(1);
            end else begin
                n_x = '0;
                if (!last_col) begin
                    n_col = r_col + CW'(1);
                end else begin
                    n_col = '0;
                    if (!last_line) begin
                        n_line = r_line + XW'(1);
                    end else begin
                        n_line = '0;
                        n_row  = last_row ? '0 : r_row + RW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_line <= '0;
            r_col  <= '0;
            r_row  <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            r_x    <= n_x;
            r_line <= n_line;
            r_col  <= n_col;
            r_row  <= n_row;
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            unique case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seg <= seg_next;
        end
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

### sv/tnpc_back.sv
// Back end: line store update, tile index, frame total and result queue
module tnpc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  tnpc_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output tnpc_pkg::t_result o_res
);

    localparam int CW = tnpc_pkg::COL_W;
    localparam int SM = tnpc_pkg::SUM_W;
    localparam int PD = tnpc_pkg::PROD_W;
    localparam int TW = tnpc_pkg::TOTAL_W;
    localparam int PW = tnpc_pkg::OUT_PTR_W;
    localparam int NW = tnpc_pkg::OUT_CNT_W;

    // stage A: line store read and index multiply
    logic [PD-1:0] idx_full;

    // stage B: add and write back
    logic                             r_b_valid;
    tnpc_pkg::t_cmd                   r_b_cmd;
    logic [tnpc_pkg::INDEX_W-1:0]     r_b_idx;
    logic [SM-1:0]                    rdata, base, sum;
    logic                             r_fwd_valid;
    logic [CW-1:0]                    r_fwd_col;
    logic [SM-1:0]                    r_fwd_sum;
    logic                             fwd_hit, emit;
    logic [TW-1:0]                    r_total, total_new;
    tnpc_pkg::t_result                res_in;

    tnpc_pkg::t_result r_oq [tnpc_pkg::OUT_DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [NW-1:0]     r_cnt;
    logic              out_pop;

    // keep one slot free for the run already in stage B
    assign o_cmd_pop = i_cmd_valid &&
        ((NW+1)'(r_cnt) + (NW+1)'(r_b_valid) < (NW+1)'(tnpc_pkg::OUT_DEPTH));

    assign idx_full = PD'(i_cmd.flipped) * PD'(i_cmd.cols) + PD'(i_cmd.col);

    tnpc_ram #(
        .WIDTH (SM),
        .DEPTH (tnpc_pkg::MAX_COLUMNS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_cmd.col),
        .i_wdata (sum),
        .i_re    (o_cmd_pop),
        .i_raddr (i_cmd.col),
        .o_rdata (rdata)
    );

    always_comb begin
        // write of the previous cycle is not yet visible in the read data
        fwd_hit   = r_fwd_valid && (r_fwd_col == r_b_cmd.col);
        if (r_b_cmd.first_line) begin
            base = '0;
        end else if (fwd_hit) begin
            base = r_fwd_sum;
        end else begin
            base = rdata;
        end
        sum       = base + SM'(r_b_cmd.seg);
        emit      = r_b_valid && r_b_cmd.last_line;
        total_new = r_total + TW'(sum);

        res_in.tile_count    = tnpc_pkg::COUNT_W'(sum);
        res_in.tile_index    = r_b_idx;
        res_in.running_total = total_new;
        res_in.frame_done    = r_b_cmd.frame_last;
    end

    assign o_empty = (r_cnt == '0);
    assign out_pop = i_pop && !o_empty;
    assign o_res   = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_total     <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
        end else begin
            r_b_valid   <= o_cmd_pop;
            r_fwd_valid <= r_b_valid;
            if (emit) begin
                r_total <= r_b_cmd.frame_last ? '0 : total_new;
                r_wp    <= r_wp + PW'(1);
            end
            if (out_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            unique case ({emit, out_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_b_cmd <= i_cmd;
            r_b_idx <= tnpc_pkg::INDEX_W'(idx_full);
        end
        r_fwd_col <= r_b_cmd.col;
        r_fwd_sum <= sum;
        if (emit) begin
            r_oq[r_wp] <= res_in;
        end
    end

endmodule

### sv/tile_nonzero_pixel_counter_core.sv
// Tile nonzero pixel counter: top level with grid configuration registers
// Pixels arrive on a queue-style input (i_push / o_full) in raster order, top
// row first; any nonzero pixel counts as set. Each tile of TILE_SIZE x TILE_SIZE
// pixels yields one transaction on the result side (o_empty / i_pop) carrying
// its count, the bottom-first grid index, the running frame total and a flag
// on the frame's last tile, after which all counters wrap.
// Grid size is set through i_cfg_we / i_cfg_index / i_cfg_data (index 0: tile
// columns, index 1: tile rows); write only while the block is idle.
// Throughput: one pixel per cycle while results are popped. The front end folds each
// run of TILE_SIZE pixels of a tile line into one command; the back end takes one
// command per cycle while the result queue has room, through a read-add-write of the
// line store (64 x 7 RAM, write-to-read forwarding), so it never limits the pixel rate.
// A tile's last command passes the command queue and stage B before the result queue.
// Reset (synchronous, active low) clears counters, queues and frame total and
// sets both grid registers to 64; the line store needs no clearing.
// When the receiver stalls the result queue fills, the back end stops taking
// commands, the command queue fills and o_full then holds off new pixels.
module tile_nonzero_pixel_counter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [tnpc_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                           o_full,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [tnpc_pkg::COUNT_W-1:0]   o_tile_count,
    output logic [tnpc_pkg::INDEX_W-1:0]   o_tile_index,
    output logic [tnpc_pkg::TOTAL_W-1:0]   o_running_total,
    output logic                           o_frame_done,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [tnpc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int MW = tnpc_pkg::CMP_W;
    localparam int FW = tnpc_pkg::CFG_W;

    logic [FW-1:0]      r_grid_columns;
    logic [FW-1:0]      r_grid_rows_used;
    tnpc_pkg::t_cols    cols;
    tnpc_pkg::t_rows    rows;
    logic               cmd_valid, cmd_pop;
    tnpc_pkg::t_cmd     cmd;
    tnpc_pkg::t_result  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns   <= FW'(tnpc_pkg::CFG_RESET_COLUMNS);
            r_grid_rows_used <= FW'(tnpc_pkg::CFG_RESET_ROWS);
        end else if (i_cfg_we) begin
            unique case (tnpc_pkg::t_cfg_index'(i_cfg_index))
                tnpc_pkg::CFG_GRID_COLUMNS:   r_grid_columns   <= i_cfg_data;
                tnpc_pkg::CFG_GRID_ROWS_USED: r_grid_rows_used <= i_cfg_data;
            endcase
        end
    end

    // zero reads as one, anything above the maximum reads as the maximum
    always_comb begin
        if (r_grid_columns == '0) begin
            cols = tnpc_pkg::t_cols'(1);
        end else if (MW'(r_grid_columns) > MW'(tnpc_pkg::MAX_COLUMNS)) begin
            cols = tnpc_pkg::t_cols'(tnpc_pkg::MAX_COLUMNS);
        end else begin
            cols = tnpc_pkg::t_cols'(r_grid_columns);
        end
        if (r_grid_rows_used == '0) begin
            rows = tnpc_pkg::t_rows'(1);
        end else if (MW'(r_grid_rows_used) > MW'(tnpc_pkg::MAX_ROWS)) begin
            rows = tnpc_pkg::t_rows'(tnpc_pkg::MAX_ROWS);
        end else begin
            rows = tnpc_pkg::t_rows'(r_grid_rows_used);
        end
    end

    tnpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_pixel     (i_pixel),
        .o_full      (o_full),
        .i_cols      (cols),
        .i_rows      (rows),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    tnpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_res       (res)
    );

    assign o_tile_count    = res.tile_count;
    assign o_tile_index    = res.tile_index;
    assign o_running_total = res.running_total;
    assign o_frame_done    = res.frame_done;

endmodule

### sv/tnpc_checker.sv
// Port-level checker for the tile counter, bound to the top level
`include "tile_nonzero_pixel_counter_core_assert.svh"

module tnpc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_full,
    input logic                           o_empty,
    input logic                           i_pop,
    input logic [tnpc_pkg::COUNT_W-1:0]   o_tile_count,
    input logic [tnpc_pkg::INDEX_W-1:0]   o_tile_index,
    input logic [tnpc_pkg::TOTAL_W-1:0]   o_running_total,
    input logic                           o_frame_done
);

    `TNPC_ASSERT_NOW(a_idle_after_reset, i_clk, i_rst_n, $past(!i_rst_n), o_empty && !o_full)

    `TNPC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_tile_count) && $stable(o_tile_index) && $stable(o_running_total) && $stable(o_frame_done))

    `TNPC_ASSERT_NOW(a_count_range, i_clk, i_rst_n, !o_empty, o_tile_count <= tnpc_pkg::TILE_SIZE * tnpc_pkg::TILE_SIZE)

    `TNPC_ASSERT_NOW(a_total_covers_count, i_clk, i_rst_n, !o_empty, o_running_total >= tnpc_pkg::TOTAL_W'(o_tile_count))

endmodule

bind tile_nonzero_pixel_counter_core tnpc_checker u_tnpc_checker (.*);
